@@ rtl/chacha_pkg.sv @@
`default_nettype none

package chacha_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  // Each double round runs as four half quarter-round steps on four lanes.
  localparam int RND_STEPS = DOUBLE_ROUNDS * 4;
  localparam int RND_W = $clog2(RND_STEPS);
  localparam int BUF_BYTES = 64;
  localparam int WORDS = 16;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_NONCE0 = 3'd4;
  localparam logic [2:0] REG_NONCE1 = 3'd5;

  typedef logic [3:0][63:0] key_t;

  typedef struct packed {
    logic       restart;
    logic       load;
    logic       round;
    logic       diag;
    logic       half;
    logic       ffwd;
    logic [3:0] ff_idx;
    logic       finish;
    logic       issue;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic buf_empty;
    logic advance;
  } status_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Initial ChaCha state word k for the current key, nonce and block counter.
  function automatic logic [31:0] init_word(input logic [3:0] k, input key_t key,
                                            input logic [63:0] nonce0,
                                            input logic [31:0] nonce1,
                                            input logic [31:0] counter);
    logic [31:0] w;
    unique case (k)
      4'd0:  w = SIGMA0;
      4'd1:  w = SIGMA1;
      4'd2:  w = SIGMA2;
      4'd3:  w = SIGMA3;
      4'd4:  w = key[0][31:0];
      4'd5:  w = key[0][63:32];
      4'd6:  w = key[1][31:0];
      4'd7:  w = key[1][63:32];
      4'd8:  w = key[2][31:0];
      4'd9:  w = key[2][63:32];
      4'd10: w = key[3][31:0];
      4'd11: w = key[3][63:32];
      4'd12: w = counter;
      4'd13: w = nonce0[31:0];
      4'd14: w = nonce0[63:32];
      4'd15: w = nonce1;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/chacha20_keystream_generator.sv @@
// When the buffer still holds bytes, the first byte of a request reaches m_tdata
// through the emit state, the memory read register and the output register.
// Throughput: one byte per cycle while m_tready is not held low; whenever the
// buffer runs out, a refill (one empty check, one load, 40 half quarter-round
// steps, 16 feed-forward writes) is inserted, and the input is ready again in the
// cycle after the last byte of a request is issued. Reset (rst, synchronous): key,
// nonce and counter zero, buffer empty.
`default_nettype none

module chacha20_keystream_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [6:0] byte_count, [7] zero
  input  wire logic        s_tuser,   // [0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] random_byte
  output logic             m_tlast
);

  chacha_pkg::cmd_t    cmd;
  chacha_pkg::status_t status;

  chacha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  chacha_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/chacha_ctrl.sv @@
`default_nettype none

module chacha_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,
  input  wire logic                 s_tuser,
  input  wire chacha_pkg::status_t  status,
  output chacha_pkg::cmd_t          cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EMIT  = 5'b00010,
    S_LOAD  = 5'b00100,
    S_ROUND = 5'b01000,
    S_FFWD  = 5'b10000
  } state_t;

  localparam logic [chacha_pkg::RND_W-1:0] RND_LAST =
    chacha_pkg::RND_W'(chacha_pkg::RND_STEPS - 1);
  localparam logic [chacha_pkg::RND_W-1:0] RND_ONE = chacha_pkg::RND_W'(1);
  localparam logic [6:0] MAX_COUNT = 7'(chacha_pkg::BUF_BYTES);

  state_t                        state, state_next;
  logic [6:0]                    rem, rem_next;
  logic [chacha_pkg::RND_W-1:0]  rnd, rnd_next;
  logic [3:0]                    ffi, ffi_next;
  logic [6:0]                    req_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rem   <= '0;
      rnd   <= '0;
      ffi   <= '0;
    end else begin
      state <= state_next;
      rem   <= rem_next;
      rnd   <= rnd_next;
      ffi   <= ffi_next;
    end
  end

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    rem_next   = rem;
    rnd_next   = rnd;
    ffi_next   = ffi;
    // Counts above one buffer saturate to a full buffer.
    req_cnt    = (s_tdata[6:0] > MAX_COUNT) ? MAX_COUNT : s_tdata[6:0];
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser) begin
            cmd.restart = 1'b1;
          end else if (req_cnt != 7'd0) begin
            rem_next   = req_cnt;
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (status.buf_empty) begin
          state_next = S_LOAD;
        end else if (status.advance) begin
          cmd.issue = 1'b1;
          cmd.last  = (rem == 7'd1);
          rem_next  = rem - 7'd1;
          if (rem == 7'd1) begin
            state_next = S_IDLE;
          end
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        rnd_next   = '0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        cmd.diag  = rnd[1];
        cmd.half  = rnd[0];
        if (rnd == RND_LAST) begin
          ffi_next   = '0;
          state_next = S_FFWD;
        end else begin
          rnd_next = rnd + RND_ONE;
        end
      end
      S_FFWD: begin
        cmd.ffwd   = 1'b1;
        cmd.ff_idx = ffi;
        ffi_next   = ffi + 4'd1;
        if (ffi == 4'd15) begin
          cmd.finish = 1'b1;
          state_next = S_EMIT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/chacha_dp.sv @@
`default_nettype none

module chacha_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_data,
  input  wire chacha_pkg::cmd_t    cmd,
  output chacha_pkg::status_t      status,
  input  wire logic                m_tready,
  output logic                     m_tvalid,
  output logic [7:0]               m_tdata,
  output logic                     m_tlast
);

  chacha_pkg::key_t key;
  logic [63:0]      nonce0;
  logic [31:0]      nonce1;
  logic [31:0]      counter;
  logic [6:0]       pos;

  logic [31:0] x      [chacha_pkg::WORDS];
  logic [31:0] x_next [chacha_pkg::WORDS];
  logic [31:0] mem    [chacha_pkg::WORDS];
  logic [31:0] rd_word;
  logic [31:0] ff_word;

  logic        p1_valid;
  logic [1:0]  p1_sel;
  logic        p1_last;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        advance;
  logic        rd_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      key    <= '0;
      nonce0 <= '0;
      nonce1 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        chacha_pkg::REG_KEY0:   key[0] <= cfg_data;
        chacha_pkg::REG_KEY1:   key[1] <= cfg_data;
        chacha_pkg::REG_KEY2:   key[2] <= cfg_data;
        chacha_pkg::REG_KEY3:   key[3] <= cfg_data;
        chacha_pkg::REG_NONCE0: nonce0 <= cfg_data;
        chacha_pkg::REG_NONCE1: nonce1 <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Position 64 marks the buffer as used up.
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      counter <= '0;
      pos     <= 7'(chacha_pkg::BUF_BYTES);
    end else if (cmd.finish) begin
      counter <= counter + 32'd1;
      pos     <= '0;
    end else if (rd_en) begin
      pos <= pos + 7'd1;
    end
  end

  // The four lanes each run one half of a quarter round per cycle. On the
  // diagonal rounds lane i takes rows 1..3 from columns i+1, i+2 and i+3.
  always_comb begin
    logic [1:0]  bi, ci, di;
    logic [31:0] a, b, c, d, a1, b1, c1, d1;
    x_next = x;
    bi = '0; ci = '0; di = '0;
    a  = '0; b  = '0; c  = '0; d  = '0;
    a1 = '0; b1 = '0; c1 = '0; d1 = '0;
    if (cmd.load) begin
      for (int k = 0; k < chacha_pkg::WORDS; k++) begin
        x_next[k] = chacha_pkg::init_word(4'(k), key, nonce0, nonce1, counter);
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 4; i++) begin
        bi = cmd.diag ? 2'(i + 1) : 2'(i);
        ci = cmd.diag ? 2'(i + 2) : 2'(i);
        di = cmd.diag ? 2'(i + 3) : 2'(i);
        a  = x[{2'd0, 2'(i)}];
        b  = x[{2'd1, bi}];
        c  = x[{2'd2, ci}];
        d  = x[{2'd3, di}];
        a1 = a + b;
        d1 = cmd.half ? chacha_pkg::rotl(d ^ a1, 8) : chacha_pkg::rotl(d ^ a1, 16);
        c1 = c + d1;
        b1 = cmd.half ? chacha_pkg::rotl(b ^ c1, 7) : chacha_pkg::rotl(b ^ c1, 12);
        x_next[{2'd0, 2'(i)}] = a1;
        x_next[{2'd1, bi}]    = b1;
        x_next[{2'd2, ci}]    = c1;
        x_next[{2'd3, di}]    = d1;
      end
    end else if (cmd.ffwd) begin
      // Rotate the state so that word ff_idx sits in x[0] at step ff_idx.
      for (int k = 0; k < chacha_pkg::WORDS - 1; k++) begin
        x_next[k] = x[k + 1];
      end
      x_next[chacha_pkg::WORDS - 1] = x[0];
    end
  end

  always_ff @(posedge clk) begin
    x <= x_next;
  end

  assign ff_word = x[0] + chacha_pkg::init_word(cmd.ff_idx, key, nonce0, nonce1, counter);

  always_ff @(posedge clk) begin
    if (cmd.ffwd) begin
      mem[cmd.ff_idx] <= ff_word;
    end
    if (rd_en) begin
      rd_word <= mem[pos[5:2]];
    end
  end

  // Two-stage read pipeline: the memory read stage and the output register
  // advance together whenever the output register is free or being taken.
  assign advance = !out_valid || m_tready;
  assign rd_en   = cmd.issue && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      p1_valid  <= rd_en;
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_sel   <= pos[1:0];
      p1_last  <= cmd.last;
      out_byte <= rd_word[{p1_sel, 3'b000} +: 8];
      out_last <= p1_last;
    end
  end

  assign status.buf_empty = pos[6];
  assign status.advance   = advance;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

@@ rtl/chacha_chk.sv @@
`default_nettype none

module chacha_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tlast
);

  // A stalled output transaction stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output payload changed while stalled");

  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // A nonzero request keeps the input closed while its bytes are issued.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser && (s_tdata[6:0] != 7'd0) |=> !s_tready)
    else $error("new request taken while a request is in progress");

endmodule

bind chacha20_keystream_generator chacha_chk u_chk (.*);

`default_nettype wire
